[sv/aadr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the associative directory with aging replacement.
// Used by aadr_ctrl, aadr_datapath and assoc_directory_aging_replace_unit.
package aadr_pkg;

    localparam int LINES_DEF = 10;
    localparam int KEY_W     = 64;
    localparam int LINE_W    = 4;
    localparam int AGE_W     = 31;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;           // capture operation and key
        logic match_cap;      // register the per-line match vector
        logic scan_init;      // reset the victim scan
        logic scan_step;      // examine one line
        logic lookup_commit;  // finish a lookup
        logic insert_commit;  // finish an insert
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic op;             // captured operation
        logic scan_stop;      // current scan line is the last one needed
    } t_sts;

endpackage

[sv/aadr_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine for the associative directory.
// Depends on aadr_pkg for the command and status structs.
module aadr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  aadr_pkg::t_sts i_sts,
    output aadr_pkg::t_cmd o_cmd
);
    import aadr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match_cap = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state = (i_sts.op == OP_INSERT) ? S_SCAN : S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup_commit = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_stop) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert_commit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/aadr_datapath.sv]
`timescale 1ns / 1ps
// Line storage, key comparators, victim scan and age update for the directory.
// Depends on aadr_pkg; driven by aadr_ctrl commands.
module aadr_datapath #(
    parameter int LINES = aadr_pkg::LINES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_operation,
    input  logic [aadr_pkg::KEY_W-1:0] i_key,
    input  aadr_pkg::t_cmd             i_cmd,
    output aadr_pkg::t_sts             o_sts,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [aadr_pkg::LINE_W-1:0] o_line,
    output logic                       o_victim_was_valid
);
    import aadr_pkg::*;

    localparam int IDX_W = $clog2(LINES);
    localparam int OW    = (IDX_W > LINE_W) ? IDX_W : LINE_W;

    logic [KEY_W-1:0] r_keys [LINES];
    logic [AGE_W-1:0] r_age  [LINES];
    logic [LINES-1:0] r_valid;
    logic [LINES-1:0] r_match;

    logic             r_op;
    logic [KEY_W-1:0] r_key;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_best;
    logic [AGE_W-1:0] r_best_age;

    logic             r_done;
    logic             r_hit;
    logic [LINE_W-1:0] r_line;
    logic             r_vwv;

    logic [IDX_W-1:0] hit_idx;
    logic             hit_any;
    logic             cur_valid;
    logic [AGE_W-1:0] cur_age;
    logic             age_upd;
    logic [IDX_W-1:0] keep;
    logic [OW-1:0]    line_ext;

    always_comb begin
        hit_idx = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any   = |r_match;
    assign cur_valid = r_valid[r_idx];
    assign cur_age   = r_age[r_idx];

    assign o_sts.op        = r_op;
    assign o_sts.scan_stop = !cur_valid || (r_idx == IDX_W'(LINES - 1));

    assign age_upd  = (i_cmd.lookup_commit && hit_any) || i_cmd.insert_commit;
    assign keep     = i_cmd.insert_commit ? r_best : hit_idx;
    assign line_ext = i_cmd.insert_commit ? OW'(r_best) : (hit_any ? OW'(hit_idx) : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_key <= i_key;
        end
        if (i_cmd.match_cap) begin
            for (int i = 0; i < LINES; i++) begin
                r_match[i] <= r_valid[i] && (r_keys[i] == r_key);
            end
        end
        if (i_cmd.scan_init) begin
            r_idx      <= '0;
            r_best     <= '0;
            r_best_age <= AGE_MAX;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (!cur_valid || (cur_age < r_best_age)) begin
                r_best     <= r_idx;
                r_best_age <= cur_age;
            end
        end
        if (i_cmd.insert_commit) begin
            r_keys[r_best] <= r_key;
        end
        if (age_upd) begin
            for (int i = 0; i < LINES; i++) begin
                if (IDX_W'(i) == keep) begin
                    if (i_cmd.insert_commit) begin
                        r_age[i] <= AGE_MAX;
                    end
                end else if (r_valid[i] && (r_age[i] != '0)) begin
                    r_age[i] <= r_age[i] - 1'b1;
                end
            end
        end
        if (i_cmd.lookup_commit || i_cmd.insert_commit) begin
            r_hit  <= i_cmd.lookup_commit && hit_any;
            r_line <= line_ext[LINE_W-1:0];
            r_vwv  <= i_cmd.insert_commit && r_valid[r_best];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.lookup_commit || i_cmd.insert_commit;
            if (i_cmd.insert_commit) begin
                r_valid[r_best] <= 1'b1;
            end
        end
    end

    assign o_done             = r_done;
    assign o_hit              = r_hit;
    assign o_line             = r_line;
    assign o_victim_was_valid = r_vwv;

endmodule

[sv/assoc_directory_aging_replace_unit.sv]
`timescale 1ns / 1ps
// Top level of the fully associative directory with aging-counter replacement.
// Depends on aadr_pkg, aadr_ctrl and aadr_datapath.

// A transaction is taken when start is high and busy is low. Each one gives
// exactly one result, shown for a single cycle with o_done high; the receiver
// cannot stall, so capture it in that cycle. A lookup registers the key,
// compares it against every line at once, then picks the lowest matching line
// and, on a hit, ages the others. An insert registers and compares the key the
// same way, then scans for a victim over 1 to LINES lines: one line per cycle
// is examined through a single age read port, and the scan stops at the first
// invalid line or at the last line. Since all lines are valid after LINES inserts,
// every later insert scans all LINES lines before it writes the key.
// Busy drops in the cycle the result is shown, so a new transaction can be
// accepted alongside it. Ages count down, saturating at zero; a freshly
// written line starts at the maximum age.
module assoc_directory_aging_replace_unit #(
    parameter int LINES = aadr_pkg::LINES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [aadr_pkg::KEY_W-1:0]  i_key,
    output logic                        o_done,
    output logic                        o_hit,
    output logic [aadr_pkg::LINE_W-1:0] o_line,
    output logic                        o_victim_was_valid
);
    import aadr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: accept, compare, then either commit a lookup or scan for a victim.
    aadr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Storage and arithmetic: keys, valid bits, ages, comparators, result registers.
    aadr_datapath #(
        .LINES (LINES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_operation        (i_operation),
        .i_key              (i_key),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_done             (o_done),
        .o_hit              (o_hit),
        .o_line             (o_line),
        .o_victim_was_valid (o_victim_was_valid)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for assoc_directory_aging_replace_unit: directed and random lookups
// and inserts, every reply checked against a cycle-free model of the line directory.
// Depends on aadr_pkg and the unit under test; needs nothing else.
module tb;
    import aadr_pkg::*;

    localparam int NLINES      = LINES_DEF;
    localparam int RANDOM_REQS = 2000;
    localparam int POOL_SIZE   = 24;       // more keys than lines, so evictions keep happening
    localparam int HOT_KEYS    = 8;        // a small hot set keeps the hit rate up
    localparam int PHASE_LEN   = 250;      // transactions per idling phase
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED = 40;
    // The worst case is an insert with a full victim scan plus sender gaps; allow many times that.
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [31:0] FRESH_AGE = {1'b0, AGE_MAX};

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
    } t_dir_req;

    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line;
        logic              victim_was_valid;
    } t_dir_reply;

    // Every block input holds a known value from time zero.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              i_operation = OP_LOOKUP;
    logic [KEY_W-1:0]  i_key       = '0;
    logic              busy;
    logic              o_done;
    logic              o_hit;
    logic [LINE_W-1:0] o_line;
    logic              o_victim_was_valid;

    assoc_directory_aging_replace_unit #(
        .LINES(NLINES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_key              (i_key),
        .o_done             (o_done),
        .o_hit              (o_hit),
        .o_line             (o_line),
        .o_victim_was_valid (o_victim_was_valid)
    );

    // Shadow copy of the directory: keys, valid marks and age counters per line.
    logic [KEY_W-1:0] dir_keys  [NLINES];
    logic             dir_valid [NLINES];
    logic [31:0]      dir_age   [NLINES];

    t_dir_req   pending_reqs[$];      // transactions not yet taken by the block
    t_dir_reply expected_replies[$];  // replies owed by the block, oldest first
    t_dir_reply oldest_reply;

    int accepted_count = 0;
    int reply_count    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    // Sender idle chance in percent, one entry per phase: back to back, sender idle,
    // receiver stall (the receiver cannot stall, so the sender runs back to back), both.
    int sender_idle_pct[4] = '{0, 48, 0, 15};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Age every valid line but the one kept; counters stop at zero.
    function automatic void age_all_but(int keep);
        for (int i = 0; i < NLINES; i++) begin
            if (i != keep && dir_valid[i] && dir_age[i] != 0)
                dir_age[i] = dir_age[i] - 1;
        end
    endfunction

    // Apply one transaction to the shadow directory and return the reply it owes.
    function automatic t_dir_reply resolve_request(t_dir_req req);
        t_dir_reply rsp;
        int         slot;
        rsp  = '0;
        slot = -1;
        if (req.op == OP_LOOKUP) begin
            // Lowest-numbered valid line with the key wins; a miss changes nothing.
            for (int i = 0; i < NLINES; i++) begin
                if (slot < 0 && dir_valid[i] && dir_keys[i] == req.key)
                    slot = i;
            end
            if (slot >= 0) begin
                rsp.hit  = 1'b1;
                rsp.line = LINE_W'(slot);
                age_all_but(slot);
            end
        end else begin
            // No hit check on insert: first free line, else the oldest, lowest index on a tie.
            for (int i = 0; i < NLINES; i++) begin
                if (slot < 0 && !dir_valid[i])
                    slot = i;
            end
            if (slot < 0) begin
                slot = 0;
                for (int i = 1; i < NLINES; i++) begin
                    if (dir_age[i] < dir_age[slot])
                        slot = i;
                end
            end
            rsp.victim_was_valid = dir_valid[slot];
            rsp.line             = LINE_W'(slot);
            dir_keys[slot]  = req.key;
            dir_valid[slot] = 1'b1;
            dir_age[slot]   = FRESH_AGE;
            age_all_but(slot);
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t reply %0d: %s expected %0h got %0h", $realtime, reply_count, field,
                     want, got);
    endtask

    task automatic queue_req(logic op, logic [KEY_W-1:0] key);
        t_dir_req req;
        req.op  = op;
        req.key = key;
        pending_reqs.push_back(req);
    endtask

    // Driver: hold a transaction while busy is high; once it is taken, predict its reply,
    // then present the next one or idle for this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                expected_replies.push_back(resolve_request(pending_reqs.pop_front()));
                accepted_count++;
            end
            if (pending_reqs.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct[(accepted_count / PHASE_LEN) % 4]) begin
                start       <= 1'b1;
                i_operation <= pending_reqs[0].op;
                i_key       <= pending_reqs[0].key;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: the reply strobe lasts one cycle and cannot be held off, so take it on every
    // edge where it is high and compare each field with the oldest owed reply.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with nothing outstanding", '0, '0);
            end else begin
                oldest_reply = expected_replies.pop_front();
                if (o_hit !== oldest_reply.hit)
                    report_mismatch("hit", KEY_W'(oldest_reply.hit), KEY_W'(o_hit));
                if (o_line !== oldest_reply.line)
                    report_mismatch("line", KEY_W'(oldest_reply.line), KEY_W'(o_line));
                if (o_victim_was_valid !== oldest_reply.victim_was_valid)
                    report_mismatch("victim_was_valid", KEY_W'(oldest_reply.victim_was_valid),
                                    KEY_W'(o_victim_was_valid));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies owed", cycle_count,
                     expected_replies.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        int               idx;

        for (int i = 0; i < NLINES; i++) begin
            dir_keys[i]  = '0;
            dir_valid[i] = 1'b0;
            dir_age[i]   = '0;
        end

        // Directed part: misses on an empty directory, extreme keys, hits,
        // a duplicate insert, filling every line, then evicting valid lines.
        queue_req(OP_LOOKUP, '0);
        queue_req(OP_LOOKUP, '1);
        queue_req(OP_INSERT, '0);
        queue_req(OP_INSERT, '1);
        queue_req(OP_LOOKUP, '0);
        queue_req(OP_LOOKUP, '1);
        queue_req(OP_INSERT, '1);                    // same key now in two lines
        queue_req(OP_LOOKUP, '1);                    // lower line must answer
        for (int i = 0; i < NLINES - 3; i++)
            queue_req(OP_INSERT, {$urandom, $urandom});
        queue_req(OP_INSERT, {32'h5555_5555, 32'h5555_5555});  // directory full: evict
        queue_req(OP_INSERT, {32'haaaa_aaaa, 32'haaaa_aaaa});
        queue_req(OP_LOOKUP, {32'h5555_5555, 32'h5555_5555});
        queue_req(OP_LOOKUP, {32'haaaa_aaaa, 32'haaaa_aaaa});
        queue_req(OP_LOOKUP, '0);
        queue_req(OP_LOOKUP, {$urandom, $urandom});

        // Random part: keys mostly from a pool with a hot subset so lines get hit, aged,
        // tied and evicted; a tenth are fresh random keys that miss.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < RANDOM_REQS; n++) begin
            idx = $urandom_range(1) ? $urandom_range(HOT_KEYS - 1) : $urandom_range(POOL_SIZE - 1);
            key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[idx];
            queue_req(($urandom_range(99) < 35) ? OP_INSERT : OP_LOOKUP, key);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for every transaction to be taken and every reply to arrive,
        // then watch a little longer for stray strobes.
        while (pending_reqs.size() != 0 || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
